/* rtl/core/lfsp_pkg.sv */
// lfsp_pkg: shared widths, codes and stage payload types of the steering pid block
// depends on nothing; imported by every module under rtl/core
`default_nettype none

package lfsp_pkg;

   // sensor and error sample width
   localparam int SampleBits = 12;
   localparam int NumSamples = 7;
   localparam int ReqDataW   = ((NumSamples * SampleBits + 7) / 8) * 8;

   // field positions inside req_tdata
   localparam int SlotLeftEdge  = 0;
   localparam int SlotRightEdge = 1;
   localparam int SlotCenterA   = 2;
   localparam int SlotCenterB   = 3;
   localparam int SlotErrPlus   = 4;
   localparam int SlotErrMinus  = 5;
   localparam int SlotGain      = 6;

   localparam int SpeedW     = 8;
   localparam int ActionW    = 2;
   localparam int RspDataW   = 2 * SpeedW;
   localparam int ThrW       = 12;
   localparam int KiW        = 17;
   localparam int CsrAddrW   = 3;
   localparam int CsrDataW   = KiW;
   localparam int CmpW       = (SampleBits > ThrW) ? SampleBits : ThrW;

   // datapath widths
   localparam int ErrW       = SampleBits + 1;
   localparam int DiffW      = SampleBits + 2;
   localparam int PtermW     = SampleBits + 7;
   localparam int GainBaseW  = ((SampleBits > 10) ? SampleBits : 10) + 1;
   localparam int GainW      = GainBaseW + 3;
   localparam int PdProdW    = GainW + PtermW;
   localparam int IntW       = 32;
   localparam int ItProdW    = IntW + KiW;
   localparam int ItFracW    = 16;
   localparam int ItQW       = ItProdW - ItFracW;

   // largest magnitude of (1000 - gain) * 6 * (e + 10 * d)
   localparam longint SampleMax = (longint'(1) << SampleBits) - 1;
   localparam longint GainRefL  = 1000;
   localparam longint MaxGain   = 6 * ((GainRefL > SampleMax - GainRefL) ?
                                       GainRefL : (SampleMax - GainRefL));
   localparam longint MaxPterm  = 21 * SampleMax;
   localparam int     PdMagW    = $clog2(MaxGain * MaxPterm + 1);

   // exact floor division by 10000 through a reciprocal multiply
   localparam longint PdDivisor = 10000;
   localparam int     DivShift  = PdMagW + 14;
   localparam int     RecipW    = PdMagW + 1;
   localparam logic [RecipW-1:0] Recip =
      RecipW'(((longint'(1) << DivShift) + PdDivisor - 1) / PdDivisor);
   localparam int     PdScaledW = PdMagW + RecipW;
   localparam int     PdQW      = PdScaledW - DivShift;

   localparam int PidW       = ItQW + 1;
   localparam int SpdCalcW   = PidW + 1;

   localparam logic signed [GainBaseW-1:0] GainRef   = GainBaseW'(1000);
   localparam logic signed [IntW-1:0]      IntMax    = {1'b0, {(IntW-1){1'b1}}};
   localparam logic signed [IntW-1:0]      IntMin    = {1'b1, {(IntW-1){1'b0}}};
   localparam logic [ItFracW-1:0]          ItRound   = {ItFracW{1'b1}};
   localparam logic [SpeedW-1:0]           SpeedMax  = {SpeedW{1'b1}};

   // csr register indexes
   localparam logic [CsrAddrW-1:0] RegBaseSpeed    = 3'd0;
   localparam logic [CsrAddrW-1:0] RegThrEdgeLeft  = 3'd1;
   localparam logic [CsrAddrW-1:0] RegThrEdgeRight = 3'd2;
   localparam logic [CsrAddrW-1:0] RegThrCenterA   = 3'd3;
   localparam logic [CsrAddrW-1:0] RegThrCenterB   = 3'd4;
   localparam logic [CsrAddrW-1:0] RegIntegralGain = 3'd5;

   localparam logic [SpeedW-1:0] BaseSpeedRst = 8'd200;
   localparam logic [ThrW-1:0]   ThrRst       = 12'd2048;

   typedef enum logic [ActionW-1:0] {
      ActPivotLeft  = 2'd0,
      ActPivotRight = 2'd1,
      ActPid        = 2'd2,
      ActHold       = 2'd3
   } action_type;

   typedef struct packed {
      logic        [SpeedW-1:0] base_speed;
      logic        [ThrW-1:0]   thr_edge_left;
      logic        [ThrW-1:0]   thr_edge_right;
      logic        [ThrW-1:0]   thr_center_a;
      logic        [ThrW-1:0]   thr_center_b;
      logic signed [KiW-1:0]    integral_gain;
   } cfg_type;

   typedef struct packed {
      logic [SampleBits-1:0] sensor_left_edge;
      logic [SampleBits-1:0] sensor_right_edge;
      logic [SampleBits-1:0] sensor_center_a;
      logic [SampleBits-1:0] sensor_center_b;
      logic [SampleBits-1:0] error_plus;
      logic [SampleBits-1:0] error_minus;
      logic [SampleBits-1:0] gain_sample;
   } samp_type;

   typedef struct packed {
      action_type               action;
      logic signed [GainW-1:0]  gain;
      logic signed [PtermW-1:0] pterm;
      logic signed [IntW-1:0]   integ;
   } s2_type;

   typedef struct packed {
      action_type                action;
      logic signed [PdProdW-1:0] pd_prod;
      logic signed [ItProdW-1:0] it_prod;
   } s3_type;

   typedef struct packed {
      action_type              action;
      logic [PdScaledW-1:0]    pd_scaled;
      logic                    pd_neg;
      logic signed [ItQW-1:0]  it_q;
   } s4_type;

   // handshake of one pipeline stage
   typedef struct packed {
      logic valid;
      logic enable;
   } stage_ctl_type;

   typedef struct packed {
      logic load_s3;
      logic load_s4;
   } mult_ctl_type;

endpackage

`default_nettype wire

/* rtl/core/line_follow_steering_pid.sv */
// line_follow_steering_pid: top level, csr registers, input register and stage handshake
// depends on lfsp_pkg, lfsp_front, lfsp_mult, lfsp_out
`default_nettype none

// Steering controller for a two-wheel line follower. Each req word is one control
// tick of seven sensor samples; each tick yields exactly one rsp word with the left
// and right wheel levels and the action taken (pivot left, pivot right, pid steering
// or hold of the last speeds). The datapath is a five-register pipeline: input
// register, mode decode with error / integral update, the two products, reciprocal
// scaling, and the result register. An accepted word moves through these registers
// in that order to rsp; one word per clock is sustained while rsp_tready stays high,
// and every stage stalls only when the stage after it is full and stalled. Integral
// and last error are updated in decode, so ticks may follow each other back to back.
// Csr writes take effect at once and must only happen while the pipeline is empty.
// No clearing pass after reset: control state resets directly, data registers do not.
module line_follow_steering_pid
   import lfsp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   // control tick in
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // sensor_left_edge, sensor_right_edge, sensor_center_a, sensor_center_b,
   // error_plus, error_minus, gain_sample, zero pad
   input  wire logic [ReqDataW-1:0]   req_tdata,

   // wheel levels out
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // left_speed, right_speed
   output      logic [RspDataW-1:0]   rsp_tdata,
   // action
   output      logic [ActionW-1:0]    rsp_tuser,

   // csr write port
   input  wire logic                  csr_we,
   input  wire logic [CsrAddrW-1:0]   csr_addr,
   input  wire logic [CsrDataW-1:0]   csr_wdata
);

   cfg_type       cfg_ff;
   samp_type      samp_ff;
   samp_type      samp_in;
   logic          v1_ff;
   logic          v2_ff;
   logic          v3_ff;
   logic          v4_ff;
   logic          en1;
   logic          en2;
   logic          en3;
   logic          en4;
   logic          en_out;

   s2_type        s2;
   s4_type        s4;
   stage_ctl_type front_ctl;
   stage_ctl_type out_ctl;
   mult_ctl_type  mult_ctl;

   logic [SpeedW-1:0] left_speed;
   logic [SpeedW-1:0] right_speed;
   action_type        action;

   // csr registers: user must write only while the pipeline is idle; not enforced
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_speed     <= BaseSpeedRst;
         cfg_ff.thr_edge_left  <= ThrRst;
         cfg_ff.thr_edge_right <= ThrRst;
         cfg_ff.thr_center_a   <= ThrRst;
         cfg_ff.thr_center_b   <= ThrRst;
         cfg_ff.integral_gain  <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            RegBaseSpeed:    cfg_ff.base_speed     <= csr_wdata[SpeedW-1:0];
            RegThrEdgeLeft:  cfg_ff.thr_edge_left  <= csr_wdata[ThrW-1:0];
            RegThrEdgeRight: cfg_ff.thr_edge_right <= csr_wdata[ThrW-1:0];
            RegThrCenterA:   cfg_ff.thr_center_a   <= csr_wdata[ThrW-1:0];
            RegThrCenterB:   cfg_ff.thr_center_b   <= csr_wdata[ThrW-1:0];
            RegIntegralGain: cfg_ff.integral_gain  <= $signed(csr_wdata[KiW-1:0]);
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // stage advance: a stage takes a new word when it is empty or its word moves on
   always_comb begin
      en_out     = !rsp_tvalid || rsp_tready;
      en4        = !v4_ff || en_out;
      en3        = !v3_ff || en4;
      en2        = !v2_ff || en3;
      en1        = !v1_ff || en2;
      req_tready = en1;

      front_ctl.valid    = v1_ff;
      front_ctl.enable   = en2;
      mult_ctl.load_s3   = en3;
      mult_ctl.load_s4   = en4;
      out_ctl.valid      = v4_ff;
      out_ctl.enable     = en_out;
   end

   // unpack the req word
   always_comb begin
      samp_in.sensor_left_edge  = req_tdata[SlotLeftEdge  * SampleBits +: SampleBits];
      samp_in.sensor_right_edge = req_tdata[SlotRightEdge * SampleBits +: SampleBits];
      samp_in.sensor_center_a   = req_tdata[SlotCenterA   * SampleBits +: SampleBits];
      samp_in.sensor_center_b   = req_tdata[SlotCenterB   * SampleBits +: SampleBits];
      samp_in.error_plus        = req_tdata[SlotErrPlus   * SampleBits +: SampleBits];
      samp_in.error_minus       = req_tdata[SlotErrMinus  * SampleBits +: SampleBits];
      samp_in.gain_sample       = req_tdata[SlotGain      * SampleBits +: SampleBits];
   end

   // valid flags of the inner stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_tvalid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (en1) begin
         samp_ff <= samp_in;
      end
   end

   lfsp_front u_front (
      .clock (clock),
      .reset (reset),
      .ctl   (front_ctl),
      .samp  (samp_ff),
      .cfg   (cfg_ff),
      .s2_ff (s2)
   );

   lfsp_mult u_mult (
      .clock         (clock),
      .ctl           (mult_ctl),
      .s2            (s2),
      .integral_gain (cfg_ff.integral_gain),
      .s4_ff         (s4)
   );

   lfsp_out u_out (
      .clock        (clock),
      .reset        (reset),
      .ctl          (out_ctl),
      .s4           (s4),
      .base_speed   (cfg_ff.base_speed),
      .rsp_valid_ff (rsp_tvalid),
      .left_ff      (left_speed),
      .right_ff     (right_speed),
      .action_ff    (action)
   );

   assign rsp_tdata = {right_speed, left_speed};
   assign rsp_tuser = action;

endmodule

`default_nettype wire

/* rtl/core/lfsp_front.sv */
// lfsp_front: mode decode, error terms and integral / last error state
// depends on lfsp_pkg
`default_nettype none

module lfsp_front
   import lfsp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stage_ctl_type ctl,
   input  wire samp_type      samp,
   input  wire cfg_type       cfg,
   output      s2_type        s2_ff
);

   logic signed [IntW-1:0] integral_ff;
   logic signed [ErrW-1:0] last_error_ff;

   logic                    pivot_left;
   logic                    pivot_right;
   logic [CmpW:0]           ctr_sum;
   logic [CmpW:0]           thr_sum;
   logic                    ctr_on;
   action_type              action_in;
   logic signed [ErrW-1:0]  err;
   logic signed [DiffW-1:0] diff;
   logic signed [PtermW-1:0] diff_x;
   logic signed [PtermW-1:0] pterm_in;
   logic signed [GainBaseW-1:0] gbase;
   logic signed [GainW-1:0] gain_in;
   logic signed [IntW:0]    int_sum;
   logic signed [IntW-1:0]  integral_in;
   s2_type                  s2_in;

   always_comb begin
      pivot_left  = (CmpW'(samp.sensor_left_edge) > CmpW'(cfg.thr_edge_left)) &&
                    (CmpW'(samp.sensor_right_edge) < CmpW'(cfg.thr_edge_right));
      pivot_right = (CmpW'(samp.sensor_left_edge) < CmpW'(cfg.thr_edge_left)) &&
                    (CmpW'(samp.sensor_right_edge) > CmpW'(cfg.thr_edge_right));
      ctr_sum = (CmpW+1)'(samp.sensor_center_a) + (CmpW+1)'(samp.sensor_center_b);
      thr_sum = (CmpW+1)'(cfg.thr_center_a) + (CmpW+1)'(cfg.thr_center_b);
      ctr_on  = (ctr_sum >> 1) > (thr_sum >> 1);

      if (pivot_left) begin
         action_in = ActPivotLeft;
      end else if (pivot_right) begin
         action_in = ActPivotRight;
      end else if (ctr_on) begin
         action_in = ActPid;
      end else begin
         action_in = ActHold;
      end

      err    = $signed({1'b0, samp.error_plus}) - $signed({1'b0, samp.error_minus});
      diff   = DiffW'(err) - DiffW'(last_error_ff);
      diff_x = PtermW'(diff);
      // e + 10 * d
      pterm_in = PtermW'(err) + (diff_x <<< 3) + (diff_x <<< 1);

      // (1000 - gain sample) * 6
      gbase   = GainRef - $signed({{(GainBaseW-SampleBits){1'b0}}, samp.gain_sample});
      gain_in = (GainW'(gbase) <<< 2) + (GainW'(gbase) <<< 1);

      // saturating integral
      int_sum = (IntW+1)'(integral_ff) + (IntW+1)'(err);
      if (int_sum[IntW] != int_sum[IntW-1]) begin
         integral_in = int_sum[IntW] ? IntMin : IntMax;
      end else begin
         integral_in = int_sum[IntW-1:0];
      end

      s2_in.action = action_in;
      s2_in.gain   = gain_in;
      s2_in.pterm  = pterm_in;
      s2_in.integ  = integral_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff   <= '0;
         last_error_ff <= '0;
      end else if (ctl.valid && ctl.enable && (action_in == ActPid)) begin
         integral_ff   <= integral_in;
         last_error_ff <= err;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         s2_ff <= s2_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/lfsp_mult.sv */
// lfsp_mult: proportional and integral products, then scaling by reciprocal and shift
// depends on lfsp_pkg
`default_nettype none

module lfsp_mult
   import lfsp_pkg::*;
(
   input  wire logic          clock,
   input  wire mult_ctl_type  ctl,
   input  wire s2_type        s2,
   input  wire logic signed [KiW-1:0] integral_gain,
   output      s4_type        s4_ff
);

   s3_type s3_ff;
   s3_type s3_in;
   s4_type s4_in;

   logic signed [PdProdW-1:0] pd_abs;
   logic [PdMagW-1:0]         pd_mag;
   logic signed [ItProdW-1:0] it_bias;

   always_comb begin
      s3_in.action  = s2.action;
      s3_in.pd_prod = PdProdW'($signed(s2.gain)) * PdProdW'($signed(s2.pterm));
      s3_in.it_prod = ItProdW'(integral_gain) * ItProdW'($signed(s2.integ));
   end

   always_comb begin
      pd_abs  = s3_ff.pd_prod[PdProdW-1] ? -$signed(s3_ff.pd_prod) : $signed(s3_ff.pd_prod);
      pd_mag  = pd_abs[PdMagW-1:0];
      // round toward zero before dropping the fraction
      it_bias = $signed(s3_ff.it_prod) +
                $signed(ItProdW'(s3_ff.it_prod[ItProdW-1] ? ItRound : '0));

      s4_in.action    = s3_ff.action;
      s4_in.pd_scaled = PdScaledW'(pd_mag) * PdScaledW'(Recip);
      s4_in.pd_neg    = s3_ff.pd_prod[PdProdW-1];
      s4_in.it_q      = it_bias[ItProdW-1:ItFracW];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s3) begin
         s3_ff <= s3_in;
      end
      if (ctl.load_s4) begin
         s4_ff <= s4_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/lfsp_out.sv */
// lfsp_out: wheel speed sum and clamp, held speeds and the result register
// depends on lfsp_pkg
`default_nettype none

module lfsp_out
   import lfsp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire stage_ctl_type     ctl,
   input  wire s4_type            s4,
   input  wire logic [SpeedW-1:0] base_speed,
   output      logic              rsp_valid_ff,
   output      logic [SpeedW-1:0] left_ff,
   output      logic [SpeedW-1:0] right_ff,
   output      action_type        action_ff
);

   logic [SpeedW-1:0] held_left_ff;
   logic [SpeedW-1:0] held_right_ff;

   logic [PdQW-1:0]            pd_q;
   logic signed [PidW-1:0]     pd_x;
   logic signed [PidW-1:0]     pd_s;
   logic signed [PidW-1:0]     pid;
   logic signed [SpdCalcW-1:0] left_raw;
   logic signed [SpdCalcW-1:0] right_raw;
   logic [SpeedW-1:0]          left_pid;
   logic [SpeedW-1:0]          right_pid;
   logic [SpeedW-1:0]          left_in;
   logic [SpeedW-1:0]          right_in;

   function automatic logic [SpeedW-1:0] clamp_speed(input logic signed [SpdCalcW-1:0] v);
      logic [SpeedW-1:0] r;
      if (v[SpdCalcW-1]) begin
         r = '0;
      end else if (|v[SpdCalcW-2:SpeedW]) begin
         r = SpeedMax;
      end else begin
         r = v[SpeedW-1:0];
      end
      return r;
   endfunction

   always_comb begin
      pd_q      = s4.pd_scaled[DivShift +: PdQW];
      pd_x      = $signed(PidW'(pd_q));
      pd_s      = s4.pd_neg ? -pd_x : pd_x;
      pid       = pd_s + PidW'($signed(s4.it_q));
      left_raw  = $signed(SpdCalcW'(base_speed)) - SpdCalcW'(pid);
      right_raw = $signed(SpdCalcW'(base_speed)) + SpdCalcW'(pid);
      left_pid  = clamp_speed(left_raw);
      right_pid = clamp_speed(right_raw);

      case (s4.action)
         ActPivotLeft: begin
            left_in  = '0;
            right_in = base_speed;
         end
         ActPivotRight: begin
            left_in  = base_speed;
            right_in = '0;
         end
         ActPid: begin
            left_in  = left_pid;
            right_in = right_pid;
         end
         default: begin
            left_in  = held_left_ff;
            right_in = held_right_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         held_left_ff  <= '0;
         held_right_ff <= '0;
      end else if (ctl.enable) begin
         rsp_valid_ff <= ctl.valid;
         if (ctl.valid) begin
            held_left_ff  <= left_in;
            held_right_ff <= right_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable && ctl.valid) begin
         left_ff   <= left_in;
         right_ff  <= right_in;
         action_ff <= s4.action;
      end
   end

`ifndef SYNTH
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");

   a_pivot_left: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (action_ff == ActPivotLeft)) |-> (left_ff == '0))
      else $error("pivot left with left wheel running");

   a_pivot_right: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (action_ff == ActPivotRight)) |-> (right_ff == '0))
      else $error("pivot right with right wheel running");

   a_hold_repeats: assert property (@(posedge clock) disable iff (reset)
      (ctl.enable && ctl.valid && (s4.action == ActHold)) |=>
      ((left_ff == $past(held_left_ff)) && (right_ff == $past(held_right_ff))))
      else $error("hold result differs from held speeds");

   a_held_tracks: assert property (@(posedge clock) disable iff (reset)
      (ctl.enable && ctl.valid) |=>
      ((held_left_ff == left_ff) && (held_right_ff == right_ff)))
      else $error("held speeds out of step with last result");
`endif

endmodule

`default_nettype wire
